// File: design/arl_pkg.sv
// package: widths, register indexes, payload types and helpers for the ring allocator
`timescale 1ns / 1ps

package arl_pkg;

  // address space of the managed region
  localparam int unsigned ADDR_BITS  = 24;
  localparam int unsigned FIELD_BITS = ADDR_BITS + 1;
  localparam int unsigned SHIFT_BITS = 4;
  localparam logic [SHIFT_BITS-1:0] MAX_ALIGN_SHIFT = SHIFT_BITS'(8);
  localparam logic [SHIFT_BITS-1:0] RESET_ALIGN_SHIFT = SHIFT_BITS'(8);
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

  // configuration register indexes
  typedef enum logic [0:0] {
    CfgRegionSize = 1'b0,
    CfgAlignShift = 1'b1
  } cfg_idx_e;

  // request modes
  typedef enum logic [0:0] {
    ModeAlloc = 1'b0,
    ModeFree  = 1'b1
  } mode_e;

  typedef struct packed {
    logic [FIELD_BITS-1:0] region_size;
    logic [SHIFT_BITS-1:0] align_shift;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] free_offset;
    logic [FIELD_BITS-1:0] used_bytes;
  } state_t;

  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] size;
    logic [FIELD_BITS-1:0] mark;
  } req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] alloc_offset;
    logic                  overflow;
    logic [FIELD_BITS-1:0] free_offset_now;
    logic [FIELD_BITS-1:0] used_now;
  } rsp_t;

  // clamp a sum that may have grown by up to two bits
  function automatic logic [FIELD_BITS-1:0] sat_field(input logic [FIELD_BITS+1:0] v);
    logic [FIELD_BITS-1:0] r;
    if (v[FIELD_BITS+1:FIELD_BITS] != 2'b00) begin
      r = FIELD_MAX;
    end else begin
      r = v[FIELD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/arl_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface arl_req_if;
  import arl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [FIELD_BITS-1:0] size;
  logic [FIELD_BITS-1:0] mark;
  modport source (output valid, output mode, output size, output mark, input ready);
  modport sink   (input valid, input mode, input size, input mark, output ready);
endinterface

interface arl_rsp_if;
  import arl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] alloc_offset;
  logic                  overflow;
  logic [FIELD_BITS-1:0] free_offset_now;
  logic [FIELD_BITS-1:0] used_now;
  modport source (output valid, output alloc_offset, output overflow,
                  output free_offset_now, output used_now, input ready);
  modport sink   (input valid, input alloc_offset, input overflow,
                  input free_offset_now, input used_now, output ready);
endinterface

// File: design/arl_cfg.sv
// configuration registers of the ring allocator
`timescale 1ns / 1ps

module arl_cfg
  import arl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [FIELD_BITS-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the write index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRegionSize: cfg_d.region_size = cfg_wdata_i;
        CfgAlignShift: cfg_d.align_shift = cfg_wdata_i[SHIFT_BITS-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_size <= '0;
      cfg_q.align_shift <= RESET_ALIGN_SHIFT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/arl_step.sv
// next allocator state and response for one request
`timescale 1ns / 1ps

module arl_step
  import arl_pkg::*;
(
  input  cfg_t   cfg_i,
  input  state_t state_i,
  input  req_t   req_i,
  output state_t state_o,
  output rsp_t   rsp_o
);

  logic [SHIFT_BITS-1:0] sh;
  logic [FIELD_BITS:0]   lowmask;
  logic [FIELD_BITS:0]   aligned;
  logic [FIELD_BITS+1:0] end_sum;
  logic                  wrap;
  logic [FIELD_BITS-1:0] rest_tail;
  logic [FIELD_BITS-1:0] used_w;
  logic [FIELD_BITS-1:0] free_w;
  logic [FIELD_BITS+1:0] fit_sum;
  logic                  ovf;
  logic [FIELD_BITS-1:0] rest_mark;

  // alignment round-up, shift clamped to the largest supported alignment
  assign sh      = (cfg_i.align_shift > MAX_ALIGN_SHIFT) ? MAX_ALIGN_SHIFT
                                                         : cfg_i.align_shift;
  assign lowmask = ((FIELD_BITS+1)'(1) << sh) - (FIELD_BITS+1)'(1);
  assign aligned = ({1'b0, req_i.size} + lowmask) & ~lowmask;

  // wrap when the block does not fit before the region end
  assign end_sum   = {2'b00, state_i.free_offset} + {1'b0, aligned};
  assign wrap      = end_sum > {2'b00, cfg_i.region_size};
  assign rest_tail = (state_i.free_offset < cfg_i.region_size)
                   ? cfg_i.region_size - state_i.free_offset : '0;
  assign used_w    = wrap ? sat_field({2'b00, state_i.used_bytes} + {2'b00, rest_tail})
                          : state_i.used_bytes;
  assign free_w    = wrap ? '0 : state_i.free_offset;

  // capacity check after the wrap
  assign fit_sum = {2'b00, used_w} + {1'b0, aligned};
  assign ovf     = fit_sum > {2'b00, cfg_i.region_size};

  // tail of the region past the mark on a wrapped free
  assign rest_mark = (req_i.mark < cfg_i.region_size)
                   ? cfg_i.region_size - req_i.mark : '0;

  always_comb begin
    state_o = state_i;
    rsp_o   = '0;
    if (mode_e'(req_i.mode) == ModeAlloc) begin
      if (ovf) begin
        state_o.free_offset = free_w;
        state_o.used_bytes  = used_w;
        rsp_o.overflow      = 1'b1;
      end else begin
        state_o.free_offset = sat_field({2'b00, free_w} + {1'b0, aligned});
        state_o.used_bytes  = sat_field(fit_sum);
        rsp_o.alloc_offset  = free_w;
      end
    end else begin
      if (req_i.mark <= state_i.free_offset) begin
        state_o.used_bytes = state_i.free_offset - req_i.mark;
      end else begin
        state_o.used_bytes = sat_field({2'b00, rest_mark} + {2'b00, state_i.free_offset});
      end
    end
    rsp_o.free_offset_now = state_o.free_offset;
    rsp_o.used_now        = state_o.used_bytes;
  end

endmodule

// File: design/aligned_ring_allocator.sv
// top level of the aligned ring-buffer space allocator
`timescale 1ns / 1ps

// Ring-buffer space allocator over a region set by the region_size register.
// Requests arrive on req_i (valid/ready): mode 0 allocates size bytes rounded
// up to 2^align_shift (shift clamped to 8), mode 1 frees everything before
// mark. Each request gives exactly one response on rsp_o with the granted
// offset, an overflow flag and the free offset and used count after the request.
// A request is captured in an input register; the allocation logic works on it
// against the state registers, and the response is loaded into the output
// register while the state updates. Throughput is one request per cycle while
// the receiver takes each response: the state update is a combinational
// add/compare loop on the free offset and used count registers.
// When the receiver stalls, the response holds in the output register, one
// more request waits in the input register, and then req_i.ready drops.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i, by the user
// only while idle (not enforced by the block). Reset empties both registers,
// clears free offset and used count, sets region_size to 0 and align_shift to 8.

module aligned_ring_allocator
  import arl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [FIELD_BITS-1:0] cfg_wdata_i,
  arl_req_if.sink               req_i,
  arl_rsp_if.source             rsp_o
);

  cfg_t   cfg;
  state_t state_q, state_nxt;
  req_t   req_q, req_d;
  rsp_t   rsp_q, rsp_nxt;
  logic   req_valid_q, req_valid_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   advance;
  logic   take;

  arl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  arl_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_nxt),
    .rsp_o   (rsp_nxt)
  );

  // pipeline handshake
  assign advance     = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;
  assign take        = req_i.valid && req_i.ready;
  assign req_valid_d = take ? 1'b1 : (advance ? 1'b0 : req_valid_q);
  assign rsp_valid_d = advance ? 1'b1 : ((rsp_valid_q && rsp_o.ready) ? 1'b0 : rsp_valid_q);

  assign req_d.mode = req_i.mode;
  assign req_d.size = req_i.size;
  assign req_d.mark = req_i.mark;

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
      if (advance) begin
        state_q <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_d;
    end
    if (advance) begin
      rsp_q <= rsp_nxt;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.alloc_offset    = rsp_q.alloc_offset;
  assign rsp_o.overflow        = rsp_q.overflow;
  assign rsp_o.free_offset_now = rsp_q.free_offset_now;
  assign rsp_o.used_now        = rsp_q.used_now;

endmodule
